### hw/rtl/voxel_run_length_decoder_unit_defines.svh
// Assertion helpers shared by the decoder modules.
// Each expects signals named clock and reset in the using scope.
`ifndef VOXEL_RUN_LENGTH_DECODER_UNIT_DEFINES_SVH
`define VOXEL_RUN_LENGTH_DECODER_UNIT_DEFINES_SVH

// Same-cycle implication.
`define VRLD_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication.
`define VRLD_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

### hw/rtl/vrld_pkg.sv
package vrld_pkg;

   localparam int WORD_W      = 32;
   localparam int SIZE_W      = 9;
   localparam int CELLS_W     = 2 * SIZE_W;
   localparam int LEN_W       = 17;
   localparam int CSR_IDX_W   = 3;
   localparam int RSP_TDATA_W = 80;
   localparam int RSP_TUSER_W = 2;
   localparam int MAX_DIM_DEF = 256;

   // Configuration register indexes
   localparam logic [CSR_IDX_W-1:0] REG_SIZE_X       = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_SIZE_Y       = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_SIZE_Z       = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_RUN_ENCODED  = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_RUN_MARKER   = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_SLICE_MARKER = 3'd5;

   localparam logic [SIZE_W-1:0] SIZE_RESET         = 9'd1;
   localparam logic              RUN_ENCODED_RESET  = 1'b1;
   localparam logic [WORD_W-1:0] RUN_MARKER_RESET   = 32'd2;
   localparam logic [WORD_W-1:0] SLICE_MARKER_RESET = 32'd6;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DECODE,
      ST_DIVIDE,
      ST_INDEX,
      ST_EMIT
   } state_type;

   typedef enum logic [1:0] {
      PH_NORMAL,
      PH_COUNT,
      PH_DATA
   } phase_type;

   // Effective (clamped) configuration seen by the decoder
   typedef struct packed {
      logic [SIZE_W-1:0]  size_x;
      logic [SIZE_W-1:0]  size_y;
      logic [SIZE_W-1:0]  size_z;
      logic [CELLS_W-1:0] cells;
      logic               run_encoded;
      logic [WORD_W-1:0]  run_marker;
      logic [WORD_W-1:0]  slice_marker;
   } cfg_type;

   typedef struct packed {
      logic [7:0]       start_x;
      logic [7:0]       start_y;
      logic [7:0]       slice_z;
      logic [LEN_W-1:0] run_length;
      logic [23:0]      material;
      logic [7:0]       density;
      logic             slice_end;
      logic             volume_end;
      logic             overflow;
   } rsp_type;

endpackage

### hw/rtl/voxel_run_length_decoder_unit.sv
// Channel | Dir | Handshake              | Payload
// req     | in  | req_tvalid/req_tready  | req_tdata: word
// rsp     | out | rsp_tvalid/rsp_tready  | rsp_tdata, rsp_tuser, rsp_tlast (volume_end)
// csr     | in  | csr_valid/csr_ready    | csr_index, csr_data
//
// A word with no result goes back to idle. A slice marker, an empty-slice voxel or a run
// that reaches the slice end goes straight to emit; a plain-mode voxel passes the index
// step first. Any other run or single voxel waits on the one-bit-per-cycle divider that
// turns the cell index into x and y. req_tready is high only while no word is in work.
// A held result stalls the sequencer in its emit step until rsp_tready frees the output.
// reset is synchronous, active high; it restores register defaults, position and phase.
`include "voxel_run_length_decoder_unit_defines.svh"

module voxel_run_length_decoder_unit #(
   parameter int MAX_DIM = vrld_pkg::MAX_DIM_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   input  logic [vrld_pkg::WORD_W-1:0]      req_tdata,   // [31:0] word
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   // [7:0] start_x, [15:8] start_y, [23:16] slice_z, [40:24] run_length,
   // [64:41] material, [72:65] density, [79:73] zero
   output logic [vrld_pkg::RSP_TDATA_W-1:0] rsp_tdata,
   output logic [vrld_pkg::RSP_TUSER_W-1:0] rsp_tuser,   // [0] slice_end, [1] overflow
   output logic                             rsp_tlast,
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [vrld_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [vrld_pkg::WORD_W-1:0]      csr_data
);
   import vrld_pkg::*;

   localparam int SIZE_MAX = (1 << SIZE_W) - 1;
   localparam int DIM_CAP  = (MAX_DIM < SIZE_MAX) ? MAX_DIM : SIZE_MAX;
   localparam int CELL_W   = $clog2(DIM_CAP * DIM_CAP + 1);
   localparam int POS_W    = (DIM_CAP > 1) ? $clog2(DIM_CAP) : 1;
   localparam int IDX_W    = POS_W + SIZE_W + 1;

   cfg_type            cfg;
   state_type          state_ff, state_in, dec_next;
   phase_type          phase_ff, phase_in;
   logic [WORD_W-1:0]  word_ff;
   logic [CELL_W-1:0]  cell_ff, cell_in;
   logic [POS_W-1:0]   cur_x_ff, cur_x_in, cur_y_ff, cur_y_in, cur_z_ff, cur_z_in;
   logic [CELL_W-1:0]  pend_ff, pend_in;
   logic               clip_ff, clip_in;
   rsp_type            res_ff, res_in;
   rsp_type            rsp_ff;
   logic               rsp_tvalid_ff, rsp_tvalid_in;
   logic               req_accept, rsp_load;
   logic               div_start, div_done;
   logic [CELL_W-1:0]  div_num, div_quot;
   logic [SIZE_W-1:0]  div_rem;

   function automatic logic [7:0] pos8(logic [POS_W-1:0] p);
      logic [POS_W+7:0] t;
      t = {8'd0, p};
      return t[7:0];
   endfunction

   function automatic logic [LEN_W-1:0] len17(logic [CELL_W-1:0] v);
      logic [CELL_W+LEN_W-1:0] t;
      t = {{LEN_W{1'b0}}, v};
      return t[LEN_W-1:0];
   endfunction

   vrld_csr #(
      .MAX_DIM (MAX_DIM)
   ) u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   vrld_div #(
      .NUM_W (CELL_W)
   ) u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (div_num),
      .divisor   (cfg.size_x),
      .done      (div_done),
      .quotient  (div_quot),
      .remainder (div_rem)
   );

   assign req_accept = req_tvalid && req_tready;

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE:   if (req_accept) state_in = ST_DECODE;
         ST_DECODE: state_in = dec_next;
         ST_DIVIDE: if (div_done) state_in = ST_EMIT;
         ST_INDEX:  state_in = ST_EMIT;
         ST_EMIT:   if (!rsp_tvalid_ff || rsp_tready) state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   // Sequencer outputs
   always_comb begin
      req_tready = 1'b0;
      div_start  = 1'b0;
      rsp_load   = 1'b0;
      case (state_ff)
         ST_IDLE:   req_tready = 1'b1;
         ST_DECODE: div_start  = (dec_next == ST_DIVIDE);
         ST_EMIT:   rsp_load   = !rsp_tvalid_ff || rsp_tready;
         default: ;
      endcase
   end

   // Decode and position update
   always_comb begin
      logic [CELL_W-1:0] cells;
      logic [CELL_W-1:0] left;
      logic [CELL_W-1:0] run_len;
      logic              run_clip;
      logic              run_go;
      logic [CELL_W:0]   cell_sum;
      logic [SIZE_W:0]   xn, yn, zn;
      logic [IDX_W-1:0]  idx;
      logic              ve;

      cells = cfg.cells[CELL_W-1:0];
      left  = (cell_ff < cells) ? cells - cell_ff : '0;
      if (phase_ff == PH_DATA) begin
         run_len  = pend_ff;
         run_clip = clip_ff;
      end else if (left == '0) begin
         run_len  = '0;
         run_clip = 1'b1;
      end else begin
         run_len  = CELL_W'(1);
         run_clip = 1'b0;
      end
      cell_sum = {1'b0, cell_ff} + {1'b0, run_len};
      xn  = (SIZE_W+1)'(cur_x_ff) + (SIZE_W+1)'(1);
      yn  = (SIZE_W+1)'(cur_y_ff) + (SIZE_W+1)'(1);
      zn  = (SIZE_W+1)'(cur_z_ff) + (SIZE_W+1)'(1);
      idx = IDX_W'(cur_y_ff) * IDX_W'(cfg.size_x) + IDX_W'(cur_x_ff);
      ve  = 1'b0;
      run_go = 1'b0;

      phase_in = phase_ff;
      cell_in  = cell_ff;
      cur_x_in = cur_x_ff;
      cur_y_in = cur_y_ff;
      cur_z_in = cur_z_ff;
      pend_in  = pend_ff;
      clip_in  = clip_ff;
      res_in   = res_ff;
      dec_next = ST_IDLE;
      div_num  = cell_sum[CELL_W-1:0];

      case (state_ff)
         ST_DECODE: begin
            if (!cfg.run_encoded) begin
               res_in            = '0;
               res_in.start_x    = pos8(cur_x_ff);
               res_in.start_y    = pos8(cur_y_ff);
               res_in.slice_z    = pos8(cur_z_ff);
               res_in.run_length = LEN_W'(1);
               res_in.material   = word_ff[WORD_W-1:8];
               res_in.density    = word_ff[7:0];
               phase_in = PH_NORMAL;
               pend_in  = '0;
               clip_in  = 1'b0;
               cur_x_in = xn[POS_W-1:0];
               if (xn >= {1'b0, cfg.size_x}) begin
                  cur_x_in = '0;
                  cur_y_in = yn[POS_W-1:0];
                  if (yn >= {1'b0, cfg.size_y}) begin
                     cur_y_in = '0;
                     cur_z_in = zn[POS_W-1:0];
                     if (zn >= {1'b0, cfg.size_z}) begin
                        cur_z_in = '0;
                        ve       = 1'b1;
                     end
                  end
               end
               res_in.volume_end = ve;
               dec_next = ST_INDEX;
            end else begin
               case (phase_ff)
                  PH_COUNT: begin
                     if (word_ff > WORD_W'(left)) begin
                        pend_in = left;
                        clip_in = 1'b1;
                     end else begin
                        pend_in = word_ff[CELL_W-1:0];
                        clip_in = 1'b0;
                     end
                     phase_in = PH_DATA;
                  end
                  PH_DATA: begin
                     phase_in = PH_NORMAL;
                     run_go   = (pend_ff != '0) || clip_ff;
                  end
                  default: begin
                     if (word_ff == cfg.slice_marker) begin
                        // Slice marker wins when both markers match
                        ve                = zn >= {1'b0, cfg.size_z};
                        res_in            = '0;
                        res_in.slice_z    = pos8(cur_z_ff);
                        res_in.slice_end  = 1'b1;
                        res_in.volume_end = ve;
                        cell_in  = '0;
                        cur_x_in = '0;
                        cur_y_in = '0;
                        cur_z_in = ve ? '0 : zn[POS_W-1:0];
                        dec_next = ST_EMIT;
                     end else if (word_ff == cfg.run_marker) begin
                        phase_in = PH_COUNT;
                     end else begin
                        run_go = 1'b1;
                     end
                  end
               endcase
            end

            if (run_go) begin
               res_in          = '0;
               res_in.slice_z  = pos8(cur_z_ff);
               res_in.material = word_ff[WORD_W-1:8];
               res_in.density  = word_ff[7:0];
               if (run_len == '0) begin
                  // Nothing left in the slice: report the word as overflow
                  res_in.overflow = 1'b1;
                  dec_next        = ST_EMIT;
               end else begin
                  res_in.start_x    = pos8(cur_x_ff);
                  res_in.start_y    = pos8(cur_y_ff);
                  res_in.run_length = len17(run_len);
                  res_in.overflow   = run_clip;
                  cell_in = cell_sum[CELL_W-1:0];
                  if (cell_sum < {1'b0, cells}) begin
                     dec_next = ST_DIVIDE;
                  end else begin
                     cur_x_in = '0;
                     cur_y_in = '0;
                     dec_next = ST_EMIT;
                  end
               end
            end
         end
         ST_DIVIDE: begin
            if (div_done) begin
               cur_x_in = div_rem[POS_W-1:0];
               cur_y_in = div_quot[POS_W-1:0];
            end
         end
         ST_INDEX: cell_in = idx[CELL_W-1:0];
         default: ;
      endcase
   end

   always_comb begin
      rsp_tvalid_in = rsp_tvalid_ff;
      if (rsp_load) begin
         rsp_tvalid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_tvalid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         phase_ff      <= PH_NORMAL;
         cell_ff       <= '0;
         cur_x_ff      <= '0;
         cur_y_ff      <= '0;
         cur_z_ff      <= '0;
         pend_ff       <= '0;
         clip_ff       <= 1'b0;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         phase_ff      <= phase_in;
         cell_ff       <= cell_in;
         cur_x_ff      <= cur_x_in;
         cur_y_ff      <= cur_y_in;
         cur_z_ff      <= cur_z_in;
         pend_ff       <= pend_in;
         clip_ff       <= clip_in;
         rsp_tvalid_ff <= rsp_tvalid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         word_ff <= req_tdata;
      end
      res_ff <= res_in;
      if (rsp_load) begin
         rsp_ff <= res_ff;
      end
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = {7'd0, rsp_ff.density, rsp_ff.material, rsp_ff.run_length,
                        rsp_ff.slice_z, rsp_ff.start_y, rsp_ff.start_x};
   assign rsp_tuser  = {rsp_ff.overflow, rsp_ff.slice_end};
   assign rsp_tlast  = rsp_ff.volume_end;

   `VRLD_ASSERT_NOW(a_div_in_wait, div_done, state_ff == ST_DIVIDE,
                    "divider finished outside its wait step")
   `VRLD_ASSERT_NOW(a_slice_shape, rsp_tvalid_ff && rsp_ff.slice_end,
                    rsp_ff.run_length == '0 && !rsp_ff.overflow,
                    "slice end transaction carries a run")
   `VRLD_ASSERT_NEXT(a_emit_load, rsp_load, rsp_tvalid_ff && state_ff == ST_IDLE,
                     "result not presented after emit")
   `VRLD_ASSERT_NEXT(a_plain_phase, state_ff == ST_DECODE && !cfg.run_encoded,
                     phase_ff == PH_NORMAL, "plain word left a run phase pending")

endmodule

### hw/rtl/vrld_csr.sv
`include "voxel_run_length_decoder_unit_defines.svh"

module vrld_csr #(
   parameter int MAX_DIM = vrld_pkg::MAX_DIM_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [vrld_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [vrld_pkg::WORD_W-1:0]    csr_data,
   output vrld_pkg::cfg_type              cfg
);
   import vrld_pkg::*;

   localparam int SIZE_MAX = (1 << SIZE_W) - 1;
   localparam int DIM_CAP  = (MAX_DIM < SIZE_MAX) ? MAX_DIM : SIZE_MAX;

   logic [SIZE_W-1:0]  size_x_ff, size_y_ff, size_z_ff;
   logic               run_encoded_ff;
   logic [WORD_W-1:0]  run_marker_ff, slice_marker_ff;
   logic [CELLS_W-1:0] cells_ff, cells_in;
   logic [SIZE_W-1:0]  eff_x, eff_y, eff_z;
   logic               wr;

   function automatic logic [SIZE_W-1:0] eff_dim(logic [SIZE_W-1:0] r);
      if (r == '0) begin
         return SIZE_W'(1);
      end
      if (32'(r) > DIM_CAP) begin
         return SIZE_W'(DIM_CAP);
      end
      return r;
   endfunction

   assign csr_ready = 1'b1;
   assign wr        = csr_valid && csr_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         size_x_ff       <= SIZE_RESET;
         size_y_ff       <= SIZE_RESET;
         size_z_ff       <= SIZE_RESET;
         run_encoded_ff  <= RUN_ENCODED_RESET;
         run_marker_ff   <= RUN_MARKER_RESET;
         slice_marker_ff <= SLICE_MARKER_RESET;
      end else if (wr) begin
         case (csr_index)
            REG_SIZE_X:       size_x_ff       <= csr_data[SIZE_W-1:0];
            REG_SIZE_Y:       size_y_ff       <= csr_data[SIZE_W-1:0];
            REG_SIZE_Z:       size_z_ff       <= csr_data[SIZE_W-1:0];
            REG_RUN_ENCODED:  run_encoded_ff  <= csr_data[0];
            REG_RUN_MARKER:   run_marker_ff   <= csr_data;
            REG_SLICE_MARKER: slice_marker_ff <= csr_data;
            default: ;
         endcase
      end
   end

   assign eff_x    = eff_dim(size_x_ff);
   assign eff_y    = eff_dim(size_y_ff);
   assign eff_z    = eff_dim(size_z_ff);
   assign cells_in = CELLS_W'(eff_x * eff_y);

   // Slice area is registered from the clamped sizes, so it follows a size write in the next cycle
   always_ff @(posedge clock) begin
      if (reset) begin
         cells_ff <= CELLS_W'(1);
      end else begin
         cells_ff <= cells_in;
      end
   end

   always_comb begin
      cfg.size_x       = eff_x;
      cfg.size_y       = eff_y;
      cfg.size_z       = eff_z;
      cfg.cells        = cells_ff;
      cfg.run_encoded  = run_encoded_ff;
      cfg.run_marker   = run_marker_ff;
      cfg.slice_marker = slice_marker_ff;
   end

   `VRLD_ASSERT_NOW(a_eff_nonzero, 1'b1, eff_x != '0 && eff_y != '0 && eff_z != '0,
                    "clamped size is zero")
   `VRLD_ASSERT_NOW(a_eff_capped, 1'b1,
                    32'(eff_x) <= DIM_CAP && 32'(eff_y) <= DIM_CAP && 32'(eff_z) <= DIM_CAP,
                    "clamped size above cap")
   `VRLD_ASSERT_NEXT(a_cells_track, 1'b1,
                     cells_ff == CELLS_W'($past(eff_x) * $past(eff_y)),
                     "slice area does not follow sizes")

endmodule

### hw/rtl/vrld_div.sv
`include "voxel_run_length_decoder_unit_defines.svh"

module vrld_div #(
   parameter int NUM_W = 17
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic [NUM_W-1:0]            dividend,
   input  logic [vrld_pkg::SIZE_W-1:0] divisor,
   output logic                        done,
   output logic [NUM_W-1:0]            quotient,
   output logic [vrld_pkg::SIZE_W-1:0] remainder
);
   import vrld_pkg::*;

   localparam int CNT_W = (NUM_W > 1) ? $clog2(NUM_W) : 1;

   logic               busy_ff, busy_in;
   logic               done_ff, done_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic [NUM_W-1:0]   num_ff, num_in;
   logic [SIZE_W-1:0]  rem_ff, rem_in;
   logic [SIZE_W-1:0]  dvs_ff, dvs_in;
   logic [SIZE_W:0]    partial, diff;
   logic               fits;

   // One quotient bit per cycle, restoring
   assign partial = {rem_ff, num_ff[NUM_W-1]};
   assign diff    = partial - {1'b0, dvs_ff};
   assign fits    = partial >= {1'b0, dvs_ff};

   always_comb begin
      busy_in  = busy_ff;
      done_in  = 1'b0;
      count_in = count_ff;
      num_in   = num_ff;
      rem_in   = rem_ff;
      dvs_in   = dvs_ff;
      if (start) begin
         busy_in  = 1'b1;
         count_in = CNT_W'(NUM_W - 1);
         num_in   = dividend;
         rem_in   = '0;
         dvs_in   = divisor;
      end else if (busy_ff) begin
         num_in   = (num_ff << 1) | NUM_W'(fits);
         rem_in   = fits ? diff[SIZE_W-1:0] : partial[SIZE_W-1:0];
         count_in = count_ff - CNT_W'(1);
         if (count_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         done_ff  <= 1'b0;
         count_ff <= '0;
      end else begin
         busy_ff  <= busy_in;
         done_ff  <= done_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      num_ff <= num_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
   end

   assign done      = done_ff;
   assign quotient  = num_ff;
   assign remainder = rem_ff;

   `VRLD_ASSERT_NOW(a_start_idle, start, !busy_ff, "divide started while busy")
   `VRLD_ASSERT_NOW(a_done_quiet, done_ff, !busy_ff, "done raised while still iterating")
   `VRLD_ASSERT_NOW(a_rem_below, done_ff, rem_ff < dvs_ff, "remainder not below divisor")

endmodule
